[hw/rtl/isp_pkg.sv]
package isp_pkg;

    localparam int unsigned ADDR_W = 64;

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_ADD   = 2'd1;
    localparam logic [1:0] REQ_PRUNE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_PIECE,
        ST_RIGHT,
        ST_NEXT,
        ST_EMIT
    } state_t;

    // Outcome of testing one work piece against one skip range.
    typedef struct packed {
        logic keep;
        logic left;
        logic right;
    } cmp_t;

endpackage

[hw/rtl/isp_ifs.sv]
interface isp_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 req_type;
    logic [isp_pkg::ADDR_W-1:0] range_start;
    logic [isp_pkg::ADDR_W-1:0] range_end;

    modport source (output valid, output req_type, output range_start, output range_end,
                    input ready);
    modport sink (input valid, input req_type, input range_start, input range_end,
                  output ready);
endinterface

interface isp_res_if;
    logic                       valid;
    logic                       ready;
    logic [isp_pkg::ADDR_W-1:0] piece_start;
    logic [isp_pkg::ADDR_W-1:0] piece_end;
    logic                       piece_valid;
    logic                       overlap_seen;
    logic                       pieces_dropped;
    logic                       last_piece;

    modport source (output valid, output piece_start, output piece_end,
                    output piece_valid, output overlap_seen, output pieces_dropped,
                    output last_piece, input ready);
    modport sink (input valid, input piece_start, input piece_end,
                  input piece_valid, input overlap_seen, input pieces_dropped,
                  input last_piece, output ready);
endinterface

[hw/rtl/isp_skip_table.sv]
module isp_skip_table #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [isp_pkg::ADDR_W-1:0] wr_start,
    input  logic [isp_pkg::ADDR_W-1:0] wr_end,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [isp_pkg::ADDR_W-1:0] rd_start,
    output logic [isp_pkg::ADDR_W-1:0] rd_end
);

    logic [isp_pkg::ADDR_W-1:0] start_mem [DEPTH];
    logic [isp_pkg::ADDR_W-1:0] end_mem   [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            start_mem[wr_addr] <= wr_start;
            end_mem[wr_addr]   <= wr_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_start <= start_mem[rd_addr];
            rd_end   <= end_mem[rd_addr];
        end
    end

endmodule

[hw/rtl/isp_work_list.sv]
module isp_work_list #(
    parameter int unsigned MAX_PIECES = 8,
    parameter int unsigned LW         = 3
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       init_en,
    input  logic [isp_pkg::ADDR_W-1:0] init_start,
    input  logic [isp_pkg::ADDR_W-1:0] init_end,
    input  logic                       wr_en,
    input  logic [LW-1:0]              wr_idx,
    input  logic [isp_pkg::ADDR_W-1:0] wr_start,
    input  logic [isp_pkg::ADDR_W-1:0] wr_end,
    input  logic                       swap,
    input  logic [LW-1:0]              rd_idx,
    output logic [isp_pkg::ADDR_W-1:0] rd_start,
    output logic [isp_pkg::ADDR_W-1:0] rd_end
);

    // Two banks: the current list is read while the next one is built.
    logic [isp_pkg::ADDR_W-1:0] bank_start_reg [2][MAX_PIECES];
    logic [isp_pkg::ADDR_W-1:0] bank_end_reg   [2][MAX_PIECES];
    logic                       cur_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= 1'b0;
        end
        else if (swap)
        begin
            cur_reg <= ~cur_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (init_en)
        begin
            bank_start_reg[cur_reg][0] <= init_start;
            bank_end_reg[cur_reg][0]   <= init_end;
        end
        if (wr_en)
        begin
            bank_start_reg[~cur_reg][wr_idx] <= wr_start;
            bank_end_reg[~cur_reg][wr_idx]   <= wr_end;
        end
    end

    assign rd_start = bank_start_reg[cur_reg][rd_idx];
    assign rd_end   = bank_end_reg[cur_reg][rd_idx];

endmodule

[hw/rtl/isp_cmp_unit.sv]
module isp_cmp_unit (
    input  logic [isp_pkg::ADDR_W-1:0] piece_start,
    input  logic [isp_pkg::ADDR_W-1:0] piece_end,
    input  logic [isp_pkg::ADDR_W-1:0] skip_start,
    input  logic [isp_pkg::ADDR_W-1:0] skip_end,
    output isp_pkg::cmp_t              result
);

    // Empty or inverted ranges go through the same tests unchanged.
    always_comb
    begin
        result.keep  = (skip_end <= piece_start) || (skip_start >= piece_end);
        result.left  = skip_start > piece_start;
        result.right = skip_end < piece_end;
    end

endmodule

[hw/rtl/interval_skip_pruner.sv]
// Channel  Role    Beat
// req      sink    req_type, range_start, range_end
// res      source  piece_start, piece_end, piece_valid, overlap_seen,
//                  pieces_dropped, last_piece
//
// Clear and add complete when accepted. A prune visits the skip ranges in
// turn: a fetch, a compare of each live piece (a piece split on both sides
// takes a second step for its right part) and a swap, with every compare on
// the one shared 64-bit compare unit, and then emits the results. rst_n is
// asynchronous and empties the skip table. The block is ready for a request
// only while idle, and result beats hold in the output register until taken.
module interval_skip_pruner #(
    parameter int unsigned SKIP_DEPTH = 32,
    parameter int unsigned MAX_PIECES = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    isp_req_if.sink      req,
    isp_res_if.source    res
);

    localparam int unsigned CW = $clog2(SKIP_DEPTH + 1);
    localparam int unsigned AW = (SKIP_DEPTH > 1) ? $clog2(SKIP_DEPTH) : 1;
    localparam int unsigned PW = $clog2(MAX_PIECES + 1);
    localparam int unsigned LW = $clog2(MAX_PIECES);

    isp_pkg::state_t            state_reg, state_next;
    logic [CW-1:0]              skip_count_reg, skip_count_next;
    logic [CW-1:0]              k_reg, k_next;
    logic [PW-1:0]              nw_reg, nw_next;
    logic [PW-1:0]              nn_reg, nn_next;
    logic [PW-1:0]              w_reg, w_next;
    logic                       ovl_reg, ovl_next;
    logic                       drop_reg, drop_next;

    logic                       res_valid_reg, res_valid_next;
    logic [isp_pkg::ADDR_W-1:0] res_start_reg, res_start_next;
    logic [isp_pkg::ADDR_W-1:0] res_end_reg, res_end_next;
    logic                       res_pvalid_reg, res_pvalid_next;
    logic                       res_last_reg, res_last_next;
    logic                       res_ovl_reg, res_ovl_next;
    logic                       res_drop_reg, res_drop_next;

    logic                       req_acc;
    logic                       tbl_wr_en;
    logic                       tbl_rd_en;
    logic [isp_pkg::ADDR_W-1:0] skip_start, skip_end;
    logic                       wl_init;
    logic                       wl_swap;
    logic                       push_en;
    logic                       wl_wr_en;
    logic [isp_pkg::ADDR_W-1:0] push_start, push_end;
    logic [isp_pkg::ADDR_W-1:0] piece_start, piece_end;
    isp_pkg::cmp_t              cmp;
    logic                       w_last;
    logic                       res_load;

    assign req.ready = (state_reg == isp_pkg::ST_IDLE);
    assign req_acc   = req.valid && req.ready;
    assign w_last    = (PW'(w_reg + PW'(1)) == nw_reg);
    assign res_load  = !res_valid_reg || res.ready;

    isp_skip_table #(
        .DEPTH (SKIP_DEPTH),
        .AW    (AW)
    ) u_table (
        .clk      (clk),
        .wr_en    (tbl_wr_en),
        .wr_addr  (skip_count_reg[AW-1:0]),
        .wr_start (req.range_start),
        .wr_end   (req.range_end),
        .rd_en    (tbl_rd_en),
        .rd_addr  (k_reg[AW-1:0]),
        .rd_start (skip_start),
        .rd_end   (skip_end)
    );

    isp_work_list #(
        .MAX_PIECES (MAX_PIECES),
        .LW         (LW)
    ) u_list (
        .clk        (clk),
        .rst_n      (rst_n),
        .init_en    (wl_init),
        .init_start (req.range_start),
        .init_end   (req.range_end),
        .wr_en      (wl_wr_en),
        .wr_idx     (nn_reg[LW-1:0]),
        .wr_start   (push_start),
        .wr_end     (push_end),
        .swap       (wl_swap),
        .rd_idx     (w_reg[LW-1:0]),
        .rd_start   (piece_start),
        .rd_end     (piece_end)
    );

    isp_cmp_unit u_cmp (
        .piece_start (piece_start),
        .piece_end   (piece_end),
        .skip_start  (skip_start),
        .skip_end    (skip_end),
        .result      (cmp)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            isp_pkg::ST_IDLE:
            begin
                if (req_acc && req.req_type == isp_pkg::REQ_PRUNE)
                begin
                    if (skip_count_reg == '0)
                        state_next = isp_pkg::ST_EMIT;
                    else
                        state_next = isp_pkg::ST_FETCH;
                end
            end
            isp_pkg::ST_FETCH:
            begin
                state_next = isp_pkg::ST_PIECE;
            end
            isp_pkg::ST_PIECE:
            begin
                if (!cmp.keep && cmp.left && cmp.right)
                    state_next = isp_pkg::ST_RIGHT;
                else if (w_last)
                    state_next = isp_pkg::ST_NEXT;
            end
            isp_pkg::ST_RIGHT:
            begin
                if (w_last)
                    state_next = isp_pkg::ST_NEXT;
                else
                    state_next = isp_pkg::ST_PIECE;
            end
            isp_pkg::ST_NEXT:
            begin
                if (nn_reg == '0 || CW'(k_reg + CW'(1)) == skip_count_reg)
                    state_next = isp_pkg::ST_EMIT;
                else
                    state_next = isp_pkg::ST_FETCH;
            end
            isp_pkg::ST_EMIT:
            begin
                if (res_load && (nw_reg == '0 || w_last))
                    state_next = isp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = isp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        skip_count_next = skip_count_reg;
        k_next          = k_reg;
        nw_next         = nw_reg;
        nn_next         = nn_reg;
        w_next          = w_reg;
        ovl_next        = ovl_reg;
        drop_next       = drop_reg;
        res_valid_next  = res_valid_reg;
        res_start_next  = res_start_reg;
        res_end_next    = res_end_reg;
        res_pvalid_next = res_pvalid_reg;
        res_last_next   = res_last_reg;
        res_ovl_next    = res_ovl_reg;
        res_drop_next   = res_drop_reg;
        tbl_wr_en       = 1'b0;
        tbl_rd_en       = 1'b0;
        wl_init         = 1'b0;
        wl_swap         = 1'b0;
        push_en         = 1'b0;
        push_start      = piece_start;
        push_end        = piece_end;

        if (res.ready)
            res_valid_next = 1'b0;

        case (state_reg)
            isp_pkg::ST_IDLE:
            begin
                if (req_acc)
                begin
                    case (req.req_type)
                        isp_pkg::REQ_CLEAR:
                        begin
                            skip_count_next = '0;
                        end
                        isp_pkg::REQ_ADD:
                        begin
                            if (skip_count_reg < CW'(SKIP_DEPTH))
                            begin
                                tbl_wr_en       = 1'b1;
                                skip_count_next = CW'(skip_count_reg + CW'(1));
                            end
                        end
                        isp_pkg::REQ_PRUNE:
                        begin
                            wl_init   = 1'b1;
                            nw_next   = PW'(1);
                            k_next    = '0;
                            w_next    = '0;
                            ovl_next  = 1'b0;
                            drop_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            isp_pkg::ST_FETCH:
            begin
                tbl_rd_en = 1'b1;
                nn_next   = '0;
                w_next    = '0;
            end
            isp_pkg::ST_PIECE:
            begin
                if (cmp.keep)
                begin
                    push_en = 1'b1;
                end
                else
                begin
                    ovl_next = 1'b1;
                    if (cmp.left)
                    begin
                        push_en  = 1'b1;
                        push_end = skip_start;
                    end
                    else if (cmp.right)
                    begin
                        push_en    = 1'b1;
                        push_start = skip_end;
                    end
                end
                // A piece split on both sides stays put for its right part.
                if (cmp.keep || !(cmp.left && cmp.right))
                    w_next = PW'(w_reg + PW'(1));
            end
            isp_pkg::ST_RIGHT:
            begin
                push_en    = 1'b1;
                push_start = skip_end;
                w_next     = PW'(w_reg + PW'(1));
            end
            isp_pkg::ST_NEXT:
            begin
                wl_swap = 1'b1;
                nw_next = nn_reg;
                k_next  = CW'(k_reg + CW'(1));
                w_next  = '0;
            end
            isp_pkg::ST_EMIT:
            begin
                if (res_load)
                begin
                    res_valid_next = 1'b1;
                    res_ovl_next   = ovl_reg;
                    res_drop_next  = drop_reg;
                    if (nw_reg == '0)
                    begin
                        res_start_next  = '0;
                        res_end_next    = '0;
                        res_pvalid_next = 1'b0;
                        res_last_next   = 1'b1;
                    end
                    else
                    begin
                        res_start_next  = piece_start;
                        res_end_next    = piece_end;
                        res_pvalid_next = 1'b1;
                        res_last_next   = w_last;
                        w_next          = PW'(w_reg + PW'(1));
                    end
                end
            end
            default:
            begin
            end
        endcase

        wl_wr_en = push_en && (nn_reg < PW'(MAX_PIECES));
        if (wl_wr_en)
            nn_next = PW'(nn_reg + PW'(1));
        if (push_en && !wl_wr_en)
            drop_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= isp_pkg::ST_IDLE;
            skip_count_reg <= '0;
            k_reg          <= '0;
            nw_reg         <= '0;
            nn_reg         <= '0;
            w_reg          <= '0;
            ovl_reg        <= 1'b0;
            drop_reg       <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            skip_count_reg <= skip_count_next;
            k_reg          <= k_next;
            nw_reg         <= nw_next;
            nn_reg         <= nn_next;
            w_reg          <= w_next;
            ovl_reg        <= ovl_next;
            drop_reg       <= drop_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_start_reg  <= res_start_next;
        res_end_reg    <= res_end_next;
        res_pvalid_reg <= res_pvalid_next;
        res_last_reg   <= res_last_next;
        res_ovl_reg    <= res_ovl_next;
        res_drop_reg   <= res_drop_next;
    end

    // The flags travel with each beat, since a new prune may start and clear
    // the sequencer flags while the last beat still waits to be taken.
    assign res.valid          = res_valid_reg;
    assign res.piece_start    = res_start_reg;
    assign res.piece_end      = res_end_reg;
    assign res.piece_valid    = res_pvalid_reg;
    assign res.overlap_seen   = res_ovl_reg;
    assign res.pieces_dropped = res_drop_reg;
    assign res.last_piece     = res_last_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (nn_reg <= PW'(MAX_PIECES)) && (nw_reg <= PW'(MAX_PIECES)))
        else $error("work list count exceeds its cap");

    assert property (@(posedge clk) disable iff (!rst_n)
        skip_count_reg <= CW'(SKIP_DEPTH))
        else $error("skip table count exceeds its depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.piece_valid |-> res.last_piece)
        else $error("empty result is not marked last");

    assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && req.req_type == isp_pkg::REQ_PRUNE |=> state_reg != isp_pkg::ST_IDLE)
        else $error("prune request left the sequencer idle");
`endif

endmodule
